### sv/fixed_string_matcher_core_defines.svh
// Assertion macros shared by the matcher RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef FIXED_STRING_MATCHER_CORE_DEFINES_SVH
`define FIXED_STRING_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FSMATCH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSMATCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fsmatch_pkg.sv
// Shared types, constants and helpers for the fixed string matcher.
// No dependencies; compiled first.
package fsmatch_pkg;

  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned PAT_WORD_W   = 64;
  localparam int unsigned PAT_WORDS    = 4;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned OUT_POS_W    = 10;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam int unsigned MAX_PATTERN_DEF = 32;
  localparam int unsigned MAX_LINE_DEF    = 1024;

  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] ASCII_CASE_OFS = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT0 = 3'd0,
    CFG_PAT1 = 3'd1,
    CFG_PAT2 = 3'd2,
    CFG_PAT3 = 3'd3,
    CFG_LEN  = 3'd4,
    CFG_CASE = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [PAT_WORDS-1:0][PAT_WORD_W-1:0] pattern;
    logic [LEN_W-1:0]                     length;
    logic                                 case_fold;
  } cfg_t;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                   input logic fold_en);
    logic [CHAR_W-1:0] r;
    r = c;
    if (fold_en && (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)) begin
      r = c + ASCII_CASE_OFS;
    end
    return r;
  endfunction

endpackage

### sv/fsmatch_ifs.sv
// Valid/ready channel interfaces: text words in, result words out, config writes.
// Depends on fsmatch_pkg.
interface fsmatch_text_if;
  import fsmatch_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              line_end;
  modport source (output valid, char_in, line_end, input ready);
  modport sink   (input valid, char_in, line_end, output ready);
endinterface

interface fsmatch_res_if;
  import fsmatch_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 match_found;
  logic [OUT_POS_W-1:0] match_start;
  logic [OUT_POS_W-1:0] match_end;
  logic                 line_done;
  modport source (output valid, match_found, match_start, match_end, line_done,
                  input ready);
  modport sink   (input valid, match_found, match_start, match_end, line_done,
                  output ready);
endinterface

interface fsmatch_cfg_if;
  import fsmatch_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [PAT_WORD_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/fsmatch_cfg.sv
// Configuration register file: pattern words, pattern length, case folding.
// Depends on fsmatch_pkg and fsmatch_ifs.
module fsmatch_cfg (
  input  logic               clk,
  input  logic               rst,
  fsmatch_cfg_if.sink        cfg_wr,
  output fsmatch_pkg::cfg_t  cfg
);
  import fsmatch_pkg::*;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr.valid) begin
      unique case (cfg_idx_t'(cfg_wr.index))
        CFG_PAT0: cfg.pattern[0] <= cfg_wr.data;
        CFG_PAT1: cfg.pattern[1] <= cfg_wr.data;
        CFG_PAT2: cfg.pattern[2] <= cfg_wr.data;
        CFG_PAT3: cfg.pattern[3] <= cfg_wr.data;
        CFG_LEN:  cfg.length <= cfg_wr.data[LEN_W-1:0];
        CFG_CASE: cfg.case_fold <= cfg_wr.data[0];
        default:  ;  // unused indexes: write dropped
      endcase
    end
  end

endmodule

### sv/fsmatch_eq.sv
// Per-position byte compare: bit k set when pattern byte k equals the text byte.
// Depends on fsmatch_pkg.
module fsmatch_eq #(
  parameter int unsigned MAX_PATTERN = fsmatch_pkg::MAX_PATTERN_DEF
) (
  input  logic [fsmatch_pkg::CHAR_W-1:0] char_in,
  input  fsmatch_pkg::cfg_t              cfg,
  input  logic [fsmatch_pkg::LEN_W-1:0]  len_used,
  output logic [MAX_PATTERN-1:0]         eq
);
  import fsmatch_pkg::*;

  logic [CHAR_W-1:0] text_f;

  assign text_f = fold_char(char_in, cfg.case_fold);

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pos
    logic [CHAR_W-1:0] pat_f;
    assign pat_f = fold_char(cfg.pattern[k >> 3][(k & 7) * CHAR_W +: CHAR_W],
                             cfg.case_fold);
    // positions past the active length never hold a partial match
    assign eq[k] = (pat_f == text_f) && (len_used > LEN_W'(k));
  end

endmodule

### sv/fsmatch_engine.sv
// Input register, shift-and match state, line position and result register.
// Depends on fsmatch_pkg, fsmatch_ifs, fsmatch_eq and the assertion macros.
`include "fixed_string_matcher_core_defines.svh"

module fsmatch_engine #(
  parameter int unsigned MAX_PATTERN = fsmatch_pkg::MAX_PATTERN_DEF,
  parameter int unsigned MAX_LINE    = fsmatch_pkg::MAX_LINE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  fsmatch_text_if.sink      text_in,
  fsmatch_res_if.source     result_out,
  input  fsmatch_pkg::cfg_t cfg
);
  import fsmatch_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_LINE);
  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned W0    = (POS_W > OUT_POS_W) ? POS_W : OUT_POS_W;
  localparam int unsigned EXT_W = ((W0 > LEN_W) ? W0 : LEN_W) + 1;
  localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_LINE - 1);
  localparam logic [LEN_W-1:0] PAT_LEN  = LEN_W'(MAX_PATTERN);

  // input stage
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_last;
  logic              advance;

  // match state
  logic [MAX_PATTERN-1:0] partial, partial_next, p_step, eq;
  logic [POS_W-1:0]       pos, pos_next;
  logic [LEN_W-1:0]       len_used, len_m1;
  logic                   found;
  logic [EXT_W-1:0]       ext_pos, ext_len, ext_pos1, start_v;

  // result register
  logic                 res_valid;
  logic                 res_found;
  logic [OUT_POS_W-1:0] res_start, res_end;
  logic                 res_last;

  assign advance       = s1_valid && (!res_valid || result_out.ready);
  assign text_in.ready = !s1_valid || advance;

  assign len_used = (cfg.length > PAT_LEN) ? PAT_LEN : cfg.length;
  assign len_m1   = len_used - LEN_W'(1);

  fsmatch_eq #(.MAX_PATTERN(MAX_PATTERN)) u_eq (
    .char_in  (s1_char),
    .cfg      (cfg),
    .len_used (len_used),
    .eq       (eq)
  );

  always_comb begin
    p_step   = ((partial << 1) | MAX_PATTERN'(1)) & eq;
    found    = (len_used != '0) && p_step[len_m1[IDX_W-1:0]];
    ext_pos  = EXT_W'(pos);
    ext_len  = EXT_W'(len_used);
    ext_pos1 = ext_pos + EXT_W'(1);
    start_v  = (ext_pos1 >= ext_len) ? (ext_pos1 - ext_len) : '0;
    // a match restarts the search; a line end clears everything
    partial_next = (found || s1_last) ? '0 : p_step;
    if (s1_last) begin
      pos_next = '0;
    end else if (pos < POS_MAX) begin
      pos_next = pos + POS_W'(1);
    end else begin
      pos_next = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_in.valid && text_in.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.valid && text_in.ready) begin
      s1_char <= text_in.char_in;
      s1_last <= text_in.line_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      pos     <= '0;
    end else if (advance) begin
      partial <= partial_next;
      pos     <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_found <= found;
      res_start <= found ? start_v[OUT_POS_W-1:0] : '0;
      res_end   <= found ? ext_pos[OUT_POS_W-1:0] : '0;
      res_last  <= s1_last;
    end
  end

  assign result_out.valid       = res_valid;
  assign result_out.match_found = res_found;
  assign result_out.match_start = res_start;
  assign result_out.match_end   = res_end;
  assign result_out.line_done   = res_last;

  `FSMATCH_ASSERT_NEXT(a_line_clear, advance && s1_last, (pos == '0) && (partial == '0), "line end did not clear match state")
  `FSMATCH_ASSERT_NEXT(a_partial_len, advance, (partial >> $past(len_used)) == '0, "partial match bit beyond pattern length")
  `FSMATCH_ASSERT_NEXT(a_accept_hold, text_in.valid && text_in.ready, s1_valid, "accepted word lost in input stage")
  `FSMATCH_ASSERT_NOW(a_nomatch_zero, res_valid && !res_found, (res_start == '0) && (res_end == '0), "positions set without a match")

endmodule

### sv/fixed_string_matcher_core.sv
// Top level of the fixed string matcher: config registers plus match engine.
// Depends on fsmatch_pkg, fsmatch_ifs, fsmatch_cfg, fsmatch_engine.
//
//   channel     dir   payload                                        handshake
//   text_in     in    char_in[7:0], line_end                         valid/ready
//   result_out  out   match_found, match_start[9:0], match_end[9:0],  valid/ready
//                     line_done
//   cfg_wr      in    index[2:0], data[63:0]                         valid/ready
//
// One word in, one result word out; a new text word is taken every cycle while the result side is not stalled.
// Each text word passes the input register, then the shift-and update into the result register.
// rst (sync, active high) clears match state, line position and all config registers.
// A stalled result holds the input stage; the input register keeps taking a word
// whenever the result register is free or being drained in the same cycle.
// Config writes are always accepted (ready tied high).
module fixed_string_matcher_core #(
  parameter int unsigned MAX_PATTERN = fsmatch_pkg::MAX_PATTERN_DEF,
  parameter int unsigned MAX_LINE    = fsmatch_pkg::MAX_LINE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  fsmatch_text_if.sink  text_in,
  fsmatch_res_if.source result_out,
  fsmatch_cfg_if.sink   cfg_wr
);
  import fsmatch_pkg::*;

  // current pattern, length and case mode, shared by the compare array
  cfg_t cfg;

  fsmatch_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  // shift-and engine: per-byte compare, partial-match vector, position counter
  fsmatch_engine #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_LINE    (MAX_LINE)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_in),
    .result_out (result_out),
    .cfg        (cfg)
  );

endmodule

### verif/fixed_string_matcher_core_test.sv
// Testbench for fixed_string_matcher_core: directed and random text lines, each result word
// checked against a local shift-and model of the search.
// Needs fsmatch_pkg, fsmatch_ifs and the core.
module fixed_string_matcher_core_test;
  import fsmatch_pkg::*;

  // The index field is three bits wide, so two indexes lie past the last register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned LONG_LINE    = 1100;  // longer than MAX_LINE, so positions saturate
  localparam int unsigned PRINT_CAP    = 100;   // mismatch lines printed; all are counted

  typedef struct packed {
    logic                 found;
    logic [OUT_POS_W-1:0] first_pos;
    logic [OUT_POS_W-1:0] last_pos;
    logic                 done;
  } match_word_t;

  logic clk;
  logic rst;

  fsmatch_text_if text_if ();
  fsmatch_res_if  res_if ();
  fsmatch_cfg_if  cfg_if ();

  fixed_string_matcher_core uut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_if),
    .result_out (res_if),
    .cfg_wr     (cfg_if)
  );

  // Local copy of the registers and the search state.
  logic [PAT_WORD_W-1:0]      pat_word [PAT_WORDS];
  logic [LEN_W-1:0]           pat_len;
  logic                       fold_case;
  logic [MAX_PATTERN_DEF-1:0] prefix_bits;   // bit k: pattern bytes 0..k end at the last byte
  logic [OUT_POS_W-1:0]       line_pos;

  match_word_t       expected_words [$];
  logic [CHAR_W-1:0] line_buf [$];
  logic [CHAR_W-1:0] alpha [3];              // small alphabet of the current random setup
  int unsigned       error_count;
  int unsigned       random_items;
  bit                steady;                 // 1: neither side idles

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
    if (fold_case && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) return c + ASCII_CASE_OFS;
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] pattern_char(input int unsigned k);
    return pat_word[k / 8][8 * (k % 8) +: 8];
  endfunction

  function automatic int unsigned active_len();
    return (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : pat_len;
  endfunction

  // One text word through the shift-and search; returns the result word it causes.
  function automatic match_word_t advance_matcher(input logic [CHAR_W-1:0] c_raw,
                                                  input logic last);
    match_word_t          r;
    logic [CHAR_W-1:0]    c;
    logic [MAX_PATTERN_DEF-1:0] hit;
    int unsigned          n;
    r   = '0;
    c   = lower_ascii(c_raw);
    n   = active_len();
    hit = '0;
    for (int unsigned k = 0; k < n; k++) begin
      if (lower_ascii(pattern_char(k)) == c) hit[k] = 1'b1;
    end
    if (n == 0) begin
      prefix_bits = '0;
    end else begin
      prefix_bits = ((prefix_bits << 1) | 1) & hit;
      if (prefix_bits[n-1]) begin
        // whole pattern seen: report it and restart after it (no overlap)
        r.found     = 1'b1;
        r.last_pos  = line_pos;
        r.first_pos = (line_pos + 1 >= n) ? OUT_POS_W'(line_pos + 1 - n) : '0;
        prefix_bits = '0;
      end
    end
    r.done = last;
    if (last) begin
      prefix_bits = '0;
      line_pos    = '0;
    end else if (line_pos < MAX_LINE_DEF - 1) begin
      line_pos = line_pos + 1'b1;   // saturates at the last line position
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Every accepted result word is held against the oldest expectation.
  always @(posedge clk) begin
    match_word_t got;
    match_word_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got = {res_if.match_found, res_if.match_start, res_if.match_end, res_if.line_done};
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: %p", got));
      end else begin
        want = expected_words.pop_front();
        if (got.found !== want.found)
          report_mismatch($sformatf("match_found %b, want %b", got.found, want.found));
        if (got.first_pos !== want.first_pos)
          report_mismatch($sformatf("match_start %0d, want %0d", got.first_pos,
                                    want.first_pos));
        if (got.last_pos !== want.last_pos)
          report_mismatch($sformatf("match_end %0d, want %0d", got.last_pos, want.last_pos));
        if (got.done !== want.done)
          report_mismatch($sformatf("line_done %b, want %b", got.done, want.done));
      end
    end
  end

  // Result side stalls at random, about 8 percent of the time, except in steady stretches.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= steady || ($urandom_range(99) >= 8);
    end
  end

  // ---------------------------------------------------------------- drivers

  // Leaves valid high after the handshake; the caller either sends the next word
  // or calls drain in the same step.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    while (!steady && $urandom_range(99) < 8) begin
      text_if.valid <= 1'b0;
      @(posedge clk);
    end
    text_if.valid    <= 1'b1;
    text_if.char_in  <= c;
    text_if.line_end <= last;
    do @(posedge clk); while (!text_if.ready);
    expected_words.push_back(advance_matcher(c, last));
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic send_string(input string s);
    for (int k = 0; k < s.len(); k++) send_char(s[k], k == s.len() - 1);
  endtask

  // Stop sending and wait until every expected word is back, then the pipe latency.
  task automatic drain();
    text_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Leaves cfg valid high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_WORD_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_PAT0, CFG_PAT1, CFG_PAT2, CFG_PAT3: pat_word[idx[1:0]] = value;
      CFG_LEN:  pat_len = value[LEN_W-1:0];
      CFG_CASE: fold_case = value[0];
      default: ;  // spare indexes change nothing
    endcase
  endtask

  task automatic load_config(input logic [PAT_WORD_W-1:0] w0, input logic [PAT_WORD_W-1:0] w1,
                             input logic [PAT_WORD_W-1:0] w2, input logic [PAT_WORD_W-1:0] w3,
                             input logic [LEN_W-1:0] len, input logic fc);
    drain();
    write_reg(CFG_PAT0, w0);
    write_reg(CFG_PAT1, w1);
    write_reg(CFG_PAT2, w2);
    write_reg(CFG_PAT3, w3);
    write_reg(CFG_LEN, PAT_WORD_W'(len));
    write_reg(CFG_CASE, PAT_WORD_W'(fc));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic use_pattern(input string s, input logic fc);
    logic [PAT_WORDS*PAT_WORD_W-1:0] w;
    w = '0;
    for (int k = 0; k < s.len(); k++) w[8*k +: 8] = s[k];
    load_config(w[63:0], w[127:64], w[191:128], w[255:192], LEN_W'(s.len()), fc);
  endtask

  // ---------------------------------------------------------------- directed tests

  // Reset values: length zero, all-zero pattern. Zero bytes must not match.
  task automatic test_zero_length();
    send_char(8'h00, 1'b0);
    send_char(8'h00, 1'b1);
    load_config('1, '1, '1, '1, '0, 1'b1);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_single_byte();
    load_config(64'hFF, '1, '1, '1, 6'd1, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  // A failed partial match must keep the shorter prefix; found matches do not overlap.
  task automatic test_overlapping_prefix();
    use_pattern("aab", 1'b0);
    send_string("aaab");
    use_pattern("aba", 1'b0);
    send_string("ababa");
  endtask

  // Folding touches A-Z only: '@' and '[' sit just outside the range.
  task automatic test_case_folding();
    use_pattern("AbC", 1'b1);
    send_string("aBc");
    use_pattern("@[", 1'b1);
    send_string("`@[");
    use_pattern("Ab", 1'b0);
    send_string("aBAb");
  endtask

  task automatic test_line_boundary();
    use_pattern("ab", 1'b0);
    send_char("a", 1'b1);
    send_char("b", 1'b1);
  endtask

  // Prefix bits survive a register write in the middle of a line.
  task automatic test_midline_write();
    use_pattern("ab", 1'b0);
    send_char("x", 1'b0);
    send_char("a", 1'b0);
    drain();
    write_reg(CFG_PAT0, {48'd0, "c", "a"});
    cfg_if.valid <= 1'b0;
    send_char("c", 1'b1);
  endtask

  task automatic test_unused_index();
    drain();
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, '1);
    cfg_if.valid <= 1'b0;
    send_string("ac");
  endtask

  // ---------------------------------------------------------------- random tests

  function automatic logic [CHAR_W-1:0] random_letter();
    logic [CHAR_W-1:0] b;
    if ($urandom_range(9) == 0) return CHAR_W'($urandom_range(255));
    b = 8'h61 + CHAR_W'($urandom_range(2));
    if ($urandom_range(1)) b = b - ASCII_CASE_OFS;
    return b;
  endfunction

  // Flip case of letters at random when folding is on, so folded text still matches.
  function automatic logic [CHAR_W-1:0] vary_case(input logic [CHAR_W-1:0] b);
    logic [CHAR_W-1:0] lo;
    lo = b | ASCII_CASE_OFS;
    if (fold_case && lo >= 8'h61 && lo <= 8'h7A && $urandom_range(1)) return b ^ ASCII_CASE_OFS;
    return b;
  endfunction

  // New pattern from a small alphabet (so prefixes overlap), random bits past its end.
  task automatic random_setup(input bit short_only);
    logic [PAT_WORDS*PAT_WORD_W-1:0] w;
    logic [LEN_W-1:0]                len;
    int unsigned                     pick;
    pick = $urandom_range(99);
    if (short_only)    len = LEN_W'($urandom_range(8, 2));
    else if (pick < 8)  len = '0;
    else if (pick < 20) len = LEN_W'($urandom_range(63, 32));
    else if (pick < 30) len = LEN_W'($urandom_range(31, 7));
    else                len = LEN_W'($urandom_range(6, 1));
    for (int i = 0; i < PAT_WORDS * PAT_WORD_W / 32; i++) w[32*i +: 32] = $urandom();
    foreach (alpha[i]) alpha[i] = random_letter();
    pick = $urandom_range(19);
    if (pick < 2) begin
      // extreme: pattern all ones or all zeros, text from that byte
      w = pick[0] ? '1 : '0;
      foreach (alpha[i]) alpha[i] = w[7:0];
    end
    for (int k = 0; k < MAX_PATTERN_DEF; k++) begin
      if (k < len) w[8*k +: 8] = alpha[$urandom_range(2)];
    end
    load_config(w[63:0], w[127:64], w[191:128], w[255:192], len, 1'(($urandom_range(1))));
  endtask

  // Well-formed line: alphabet bytes with pattern copies spliced in; else plain noise.
  task automatic random_line(input int unsigned size);
    int unsigned n;
    int unsigned pos;
    n = active_len();
    line_buf.delete();
    if ($urandom_range(9) < 3) begin
      repeat (size) line_buf.push_back(CHAR_W'($urandom_range(255)));
    end else begin
      repeat (size) line_buf.push_back(vary_case(alpha[$urandom_range(2)]));
      repeat ($urandom_range(3)) begin
        if (n > 0 && size >= n) begin
          pos = $urandom_range(size - n);
          for (int unsigned k = 0; k < n; k++) line_buf[pos + k] = vary_case(pattern_char(k));
        end
      end
    end
    send_line();
  endtask

  task automatic test_random_lines();
    int unsigned phase;
    int unsigned size;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      random_setup(1'b0);
      steady = (phase == 2);   // one whole phase with no idling on either side
      repeat ($urandom_range(6, 2)) begin
        size = $urandom_range(active_len() + 24, 1);
        random_line(size);
        random_items += size;
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // One line past MAX_LINE with matches before, across and after saturation.
  task automatic test_long_line();
    int unsigned n;
    random_setup(1'b1);
    n = active_len();
    line_buf.delete();
    repeat (LONG_LINE) line_buf.push_back(vary_case(alpha[$urandom_range(2)]));
    foreach (line_buf[i]) begin
      if (i == 1020 - n || i == 1022 || i == 1060 || i == 1060 + n)
        for (int unsigned k = 0; k < n; k++) line_buf[i + k] = pattern_char(k);
    end
    send_line();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    error_count  = 0;
    random_items = 0;
    steady       = 1'b0;
    foreach (pat_word[i]) pat_word[i] = '0;
    pat_len          = '0;
    fold_case        = 1'b0;
    prefix_bits      = '0;
    line_pos         = '0;
    rst              <= 1'b1;
    text_if.valid    <= 1'b0;
    text_if.char_in  <= '0;
    text_if.line_end <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= '0;
    cfg_if.data      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_zero_length();
    test_single_byte();
    test_overlapping_prefix();
    test_case_folding();
    test_line_boundary();
    test_midline_write();
    test_unused_index();
    test_long_line();
    test_random_lines();

    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/fsmatch_pkg.sv
sv/fsmatch_ifs.sv
sv/fsmatch_cfg.sv
sv/fsmatch_eq.sv
sv/fsmatch_engine.sv
sv/fixed_string_matcher_core.sv
verif/fixed_string_matcher_core_test.sv
